// ===== design/ose_pkg.sv =====
// Shared types and constants of the one-shot event scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ose_pkg;

	localparam int TIME_W     = 32;
	localparam int CYC_W      = 28;
	localparam int KIND_W     = 2;
	localparam int SLOT_W     = 4;
	localparam int NSLOT_W    = 5;
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 96;
	localparam int OUT_USER_W = 1;

	localparam logic [KIND_W-1:0] KIND_ARM     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DISARM  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

	localparam logic [NSLOT_W-1:0] NO_SLOT    = 5'd16;
	localparam logic [TIME_W-1:0]  DISARMED   = 32'hFFFF_FFFF;
	localparam logic [CYC_W-1:0]   IDLE_RESET = 28'd200000000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic exec;
		logic fetch;
		logic step;
		logic close;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fire;
		logic out_free;
		logic scan_last;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/one_shot_event_scheduler.sv =====
// Top level of the one-shot event scheduler.
// The closing result of an item is loaded in the done state, after the execute, fetch and scan states;
// a new item is taken only once the last one has closed. The scan reads one slot a cycle
// through the slot table's single read port, and a full result register stalls the scan on a firing.
// Reset: arst_n clears time to zero, disarms every slot and restores idle_period.
`timescale 1ns / 1ps
`default_nettype none
module one_shot_event_scheduler #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ose_pkg::CYC_W-1:0]        cfg_wdata,  // idle_period
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [ose_pkg::IN_DATA_W-1:0]    s_tdata,    // slot[3:0], cycles[31:4]
	input  wire logic [ose_pkg::IN_USER_W-1:0]    s_tuser,    // kind[1:0]
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// fired_slot[3:0], span[31:4], lateness[59:32], nearest_slot[64:60],
	// nearest_distance[92:65], zero fill[95:93]
	output logic      [ose_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic      [ose_pkg::OUT_USER_W-1:0]   m_tuser,    // fired[0]
	output logic                                  m_tlast
);
	import ose_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [SLOT_W-1:0] fired_slot;
	logic [CYC_W-1:0]  span;
	logic [CYC_W-1:0]  lateness;
	logic [NSLOT_W-1:0] nearest_slot;
	logic [CYC_W-1:0]  nearest_distance;

	ose_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ose_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.in_kind              (s_tuser),
		.in_slot              (s_tdata[3:0]),
		.in_delay             (s_tdata[31:4]),
		.cmd                  (cmd),
		.sts                  (sts),
		.out_valid            (m_tvalid),
		.out_ready            (m_tready),
		.out_fired            (m_tuser[0]),
		.out_fired_slot       (fired_slot),
		.out_span             (span),
		.out_lateness         (lateness),
		.out_nearest_slot     (nearest_slot),
		.out_nearest_distance (nearest_distance),
		.out_last             (m_tlast)
	);

	assign m_tdata = {3'd0, nearest_distance, nearest_slot, lateness, span, fired_slot};

endmodule
`default_nettype wire

// ===== design/ose_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ose_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/ose_ctrl.sv =====
// Controller state machine that sequences one item through execute and slot scan.
`timescale 1ns / 1ps
`default_nettype none
module ose_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ose_pkg::sts_t sts,
	output ose_pkg::cmd_t      cmd
);
	import ose_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   step;

	// A scan step stalls only when the slot fires and the result register is still full.
	assign step = !sts.fire || sts.out_free;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.step = step;
				if (step && sts.scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.close = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.exec, cmd.fetch, cmd.step, cmd.close}))
		else $error("controller issued two commands at once");
	a_close_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> in_ready)
		else $error("controller did not return to idle after the closing item");
	a_scan_follows_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> !in_ready && !cmd.exec)
		else $error("scan did not follow fetch");
`endif

endmodule
`default_nettype wire

// ===== design/ose_dp.sv =====
// Datapath: time counter, slot table, expiry and nearest-deadline scan, result register.
`timescale 1ns / 1ps
`default_nettype none
module ose_dp #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ose_pkg::CYC_W-1:0]    cfg_wdata,
	input  wire logic [ose_pkg::KIND_W-1:0]   in_kind,
	input  wire logic [ose_pkg::SLOT_W-1:0]   in_slot,
	input  wire logic [ose_pkg::CYC_W-1:0]    in_delay,
	input  wire ose_pkg::cmd_t                cmd,
	output ose_pkg::sts_t                     sts,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              out_fired,
	output logic      [ose_pkg::SLOT_W-1:0]   out_fired_slot,
	output logic      [ose_pkg::CYC_W-1:0]    out_span,
	output logic      [ose_pkg::CYC_W-1:0]    out_lateness,
	output logic      [ose_pkg::NSLOT_W-1:0]  out_nearest_slot,
	output logic      [ose_pkg::CYC_W-1:0]    out_nearest_distance,
	output logic                              out_last
);
	import ose_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int RW = 2 * TIME_W;

	logic [CYC_W-1:0]  idle_q;
	logic [KIND_W-1:0] kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CYC_W-1:0]  cyc_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] old_q;
	logic [IW-1:0]     idx_q;
	logic [TIME_W-1:0] best_q;
	logic [IW-1:0]     best_idx_q;
	logic              found_q;
	logic [SLOT_COUNT-1:0] vld_q;
	logic              rd_vld_s1;

	logic [CYC_W-1:0]  cyc_sat;
	logic              slot_ok;
	logic [TIME_W-1:0] arm_end;
	logic [TIME_W-1:0] deadline;
	logic [TIME_W-1:0] start;
	logic [TIME_W-1:0] rem;
	logic [TIME_W-1:0] since_old;
	logic              armed;
	logic              fire;
	logic              cand;
	logic              out_free;
	logic              load_fire;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;

	assign cyc_sat = (in_delay > idle_q) ? idle_q : in_delay;
	assign slot_ok = ({28'd0, slot_q} < SLOT_COUNT);

	// An armed deadline may not take the all-ones code of a disarmed slot.
	always_comb begin
		arm_end = now_q + {4'd0, cyc_q};
		if (arm_end == DISARMED) begin
			arm_end = '0;
		end
	end

	// Entries never written read as disarmed.
	assign deadline  = rd_vld_s1 ? ram_rdata[TIME_W-1:0] : DISARMED;
	assign start     = ram_rdata[RW-1:TIME_W];
	assign armed     = (deadline != DISARMED);
	assign since_old = deadline - old_q;
	assign rem       = deadline - now_q;
	assign fire      = (kind_q == KIND_ADVANCE) && armed && (since_old <= {4'd0, cyc_q});
	assign cand      = armed && !fire && (rem < best_q);

	assign out_free  = !out_valid || out_ready;
	assign load_fire = cmd.step && fire;

	assign sts.fire      = fire;
	assign sts.out_free  = out_free;
	assign sts.scan_last = (idx_q == IW'(SLOT_COUNT - 1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {now_q, DISARMED};
		if (cmd.exec) begin
			ram_waddr = IW'(slot_q);
			if (kind_q == KIND_ARM) begin
				ram_we    = slot_ok;
				ram_wdata = {now_q, arm_end};
			end else if (kind_q == KIND_DISARM) begin
				ram_we = slot_ok;
			end
		end else if (load_fire) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		ram_raddr = idx_q;
		if (cmd.fetch) begin
			ram_raddr = '0;
		end else if (cmd.step && !sts.scan_last) begin
			ram_raddr = idx_q + IW'(1);
		end
	end

	ose_ram #(
		.WIDTH (RW),
		.DEPTH (SLOT_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q    <= IDLE_RESET;
			now_q     <= '0;
			vld_q     <= '0;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				idle_q <= cfg_wdata;
			end
			if (cmd.exec && kind_q == KIND_ADVANCE) begin
				now_q <= now_q + {4'd0, cyc_q};
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (cmd.fetch) begin
				found_q <= 1'b0;
			end else if (cmd.step && cand) begin
				found_q <= 1'b1;
			end
			if (load_fire || cmd.close) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= vld_q[ram_raddr];
		if (cmd.accept) begin
			kind_q <= in_kind;
			slot_q <= in_slot;
			cyc_q  <= cyc_sat;
		end
		if (cmd.exec) begin
			old_q <= now_q;
		end
		if (cmd.fetch) begin
			idx_q      <= '0;
			best_q     <= DISARMED;
			best_idx_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IW'(1);
			if (cand) begin
				best_q     <= rem;
				best_idx_q <= idx_q;
			end
		end
		if (load_fire) begin
			out_fired            <= 1'b1;
			out_fired_slot       <= SLOT_W'(idx_q);
			out_span             <= CYC_W'(deadline - start);
			out_lateness         <= CYC_W'(now_q - deadline);
			out_nearest_slot     <= '0;
			out_nearest_distance <= '0;
			out_last             <= 1'b0;
		end else if (cmd.close) begin
			out_fired            <= 1'b0;
			out_fired_slot       <= '0;
			out_span             <= '0;
			out_lateness         <= '0;
			out_nearest_slot     <= found_q ? NSLOT_W'(best_idx_q) : NO_SLOT;
			out_nearest_distance <= found_q ? best_q[CYC_W-1:0] : idle_q;
			out_last             <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load_fire || cmd.close) |-> out_free)
		else $error("result register loaded while still holding an item");
	a_fire_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && fire) |-> (kind_q == KIND_ADVANCE))
		else $error("slot fired outside an advance");
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && cmd.step && !sts.scan_last) |-> (ram_waddr != ram_raddr))
		else $error("table write and prefetch hit the same slot");
	a_found_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_q != DISARMED))
		else $error("nearest deadline marked found with a disarmed distance");
`endif

endmodule
`default_nettype wire

// ===== sim/one_shot_event_scheduler_test.sv =====
// Self-checking testbench for the one-shot event scheduler: directed and random items, predicted results.
`timescale 1ns / 1ps
module one_shot_event_scheduler_test;
	import ose_pkg::*;

	localparam int SLOT_COUNT   = 16;
	localparam int SCAN_LATENCY = SLOT_COUNT + 4;
	localparam int REPORT_CAP   = 60;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [CYC_W-1:0]  CYCLES_MAX  = 28'd200000000;

	typedef struct packed {
		logic              fired;
		logic [SLOT_W-1:0] fired_slot;
		logic [CYC_W-1:0]  span;
		logic [CYC_W-1:0]  lateness;
		logic [NSLOT_W-1:0] nearest_slot;
		logic [CYC_W-1:0]  nearest_distance;
		logic              last;
	} timer_report_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CYC_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;   // slot[3:0], cycles[31:4]
	logic [IN_USER_W-1:0]  s_tuser   = '0;   // kind[1:0]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// fired_slot[3:0], span[31:4], lateness[59:32], nearest_slot[64:60],
	// nearest_distance[92:65], zero fill[95:93]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;          // fired[0]
	logic                  m_tlast;

	// Timer state kept by the testbench.
	logic [TIME_W-1:0]  model_time;
	logic [TIME_W-1:0]  model_deadline [SLOT_COUNT];
	logic [TIME_W-1:0]  model_start [SLOT_COUNT];
	logic [NSLOT_W-1:0] model_soonest;
	logic [CYC_W-1:0]   model_idle;

	timer_report_t expected_reports[$];
	timer_report_t oldest_report;
	int unsigned   mismatch_count = 0;
	int unsigned   items_sent = 0;
	int unsigned   ready_hold = 0;
	int unsigned   ready_draw;
	bit            sender_steady = 1'b0;
	bit            receiver_steady = 1'b0;

	one_shot_event_scheduler #(
		.SLOT_COUNT(SLOT_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < REPORT_CAP) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// Applies one accepted item to the timer state and queues the results it causes.
	task automatic predict_item(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
			input logic [CYC_W-1:0] cycles);
		logic [TIME_W-1:0]  cyc;
		logic [TIME_W-1:0]  due;
		logic [TIME_W-1:0]  prev_time;
		logic [TIME_W-1:0]  rem;
		logic [TIME_W-1:0]  best_rem;
		logic [NSLOT_W-1:0] which;
		timer_report_t      rep;
		cyc = (cycles > model_idle) ? TIME_W'(model_idle) : TIME_W'(cycles);
		case (kind)
			KIND_ARM: begin
				due = model_time + cyc;
				// All ones means disarmed, so such a deadline is stored as zero.
				if (due == DISARMED) begin
					due = '0;
				end
				model_start[slot]    = model_time;
				model_deadline[slot] = due;
			end
			KIND_DISARM: begin
				model_start[slot]    = model_time;
				model_deadline[slot] = DISARMED;
			end
			KIND_ADVANCE: begin
				prev_time  = model_time;
				model_time = prev_time + cyc;
				if (model_soonest != NO_SLOT) begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						due = model_deadline[i];
						if (due != DISARMED && due - prev_time <= cyc) begin
							rep                  = '0;
							rep.fired            = 1'b1;
							rep.fired_slot       = SLOT_W'(i);
							rep.span             = CYC_W'(due - model_start[i]);
							rep.lateness         = CYC_W'(model_time - due);
							model_start[i]       = model_time;
							model_deadline[i]    = DISARMED;
							expected_reports     = {expected_reports, rep};
						end
					end
				end
			end
			default: begin
			end
		endcase
		best_rem = DISARMED;
		which    = NO_SLOT;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (model_deadline[i] != DISARMED) begin
				rem = model_deadline[i] - model_time;
				if (rem < best_rem) begin
					best_rem = rem;
					which    = NSLOT_W'(i);
				end
			end
		end
		model_soonest        = which;
		rep                  = '0;
		rep.nearest_slot     = which;
		rep.nearest_distance = (which == NO_SLOT) ? model_idle : CYC_W'(best_rem);
		rep.last             = 1'b1;
		expected_reports     = {expected_reports, rep};
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (sender_steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [CYC_W-1:0] rand_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			return CYC_W'($urandom_range(0, 64));
		end
		if (r < 70) begin
			return CYC_W'($urandom_range(0, 5000));
		end
		if (r < 85) begin
			return CYC_W'($urandom_range(0, CYCLES_MAX));
		end
		if (r < 90) begin
			return '0;
		end
		if (r < 95) begin
			return model_idle;
		end
		return (model_idle == CYCLES_MAX) ? CYCLES_MAX : model_idle + 1'b1;
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
			input logic [CYC_W-1:0] cycles);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = kind;
		s_tdata  = {cycles, slot};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_item(kind, slot, cycles);
		if (kind != KIND_UNUSED) begin
			items_sent++;
		end
		@(negedge clk);
	endtask

	// Holds the sender back until every expected result has been checked.
	task automatic wait_for_drain();
		s_tvalid = 1'b0;
		while (expected_reports.size() != 0) @(negedge clk);
		repeat (SCAN_LATENCY) @(negedge clk);
	endtask

	task automatic write_idle_period(input logic [CYC_W-1:0] value);
		wait_for_drain();
		cfg_wdata = value;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we     = 1'b0;
		model_idle = value;
	endtask

	// Status after reset, the unused kind and advances with nothing armed.
	task automatic test_idle_status();
		send_item(KIND_UNUSED, 4'd15, CYCLES_MAX);
		send_item(KIND_ADVANCE, 4'd0, 28'd0);
		send_item(KIND_ADVANCE, 4'd15, CYCLES_MAX);
	endtask

	// Arming, disarming, firing in slot order and the tie on equal deadlines.
	task automatic test_arm_and_fire();
		sender_steady   = 1'b1;
		receiver_steady = 1'b1;
		send_item(KIND_ARM, 4'd0, 28'd0);
		send_item(KIND_ARM, 4'd15, CYCLES_MAX);
		send_item(KIND_ARM, 4'd5, 28'd10);
		send_item(KIND_ARM, 4'd6, 28'd10);
		send_item(KIND_DISARM, 4'd15, 28'd0);
		send_item(KIND_ADVANCE, 4'd0, 28'd0);
		send_item(KIND_ADVANCE, 4'd0, 28'd10);
		send_item(KIND_DISARM, 4'd3, CYCLES_MAX);
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
	endtask

	// A zero idle period saturates every delay to zero; a period of one caps every delay at one.
	task automatic test_idle_extremes();
		write_idle_period(28'd0);
		send_item(KIND_ARM, 4'd2, 28'd500);
		send_item(KIND_ADVANCE, 4'd0, 28'd7);
		send_item(KIND_ADVANCE, 4'd0, 28'd0);
		write_idle_period(28'd1);
		send_item(KIND_ARM, 4'd12, CYCLES_MAX);
		send_item(KIND_ADVANCE, 4'd9, CYCLES_MAX);
	endtask

	// Every slot armed, then one advance that fires all of them.
	task automatic test_full_table();
		write_idle_period(28'd1000);
		for (int s = 0; s < SLOT_COUNT; s++) begin
			send_item(KIND_ARM, SLOT_W'(s), CYC_W'($urandom_range(0, 1000)));
		end
		send_item(KIND_ADVANCE, 4'd0, 28'd1000);
	endtask

	// Mostly arm sequences closed by an advance, with stray disarms and unused kinds.
	task automatic run_random_phase(input logic [CYC_W-1:0] idle, input int unsigned count);
		int unsigned target;
		int unsigned n;
		bit          paused;
		write_idle_period(idle);
		target = items_sent + count;
		paused = 1'b0;
		while (items_sent < target) begin
			sender_steady   = ($urandom_range(0, 7) == 0);
			receiver_steady = ($urandom_range(0, 7) == 0);
			if (!paused && items_sent + count / 2 >= target) begin
				wait_for_drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 99) < 80) begin
				n = ($urandom_range(0, 9) == 0) ? SLOT_COUNT : $urandom_range(1, 5);
				repeat (n) begin
					send_item(KIND_ARM, SLOT_W'($urandom), rand_cycles());
					if ($urandom_range(0, 4) == 0) begin
						send_item(KIND_DISARM, SLOT_W'($urandom), rand_cycles());
					end
				end
				send_item(KIND_ADVANCE, SLOT_W'($urandom),
					($urandom_range(0, 2) == 0) ? model_idle : rand_cycles());
			end else begin
				case ($urandom_range(0, 2))
					0: send_item(KIND_DISARM, SLOT_W'($urandom), rand_cycles());
					1: send_item(KIND_ADVANCE, SLOT_W'($urandom), rand_cycles());
					default: send_item(KIND_UNUSED, SLOT_W'($urandom), rand_cycles());
				endcase
			end
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(28'd1000, 20);
		run_random_phase(CYC_W'($urandom_range(1, CYCLES_MAX)), 15);
		run_random_phase(CYCLES_MAX, 15);
	endtask

	// Moves time up to the 32-bit wrap, arms a deadline that lands on all ones and fires it.
	task automatic test_time_wrap();
		write_idle_period(CYCLES_MAX);
		while (DISARMED - model_time > TIME_W'(model_idle)) begin
			send_item(KIND_ADVANCE, 4'd0, model_idle);
		end
		send_item(KIND_ARM, 4'd9, CYC_W'(DISARMED - model_time));
		send_item(KIND_ARM, 4'd10, CYCLES_MAX);
		send_item(KIND_ADVANCE, 4'd0, CYCLES_MAX);
		send_item(KIND_ADVANCE, 4'd0, CYCLES_MAX);
	endtask

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			m_tready = 1'b0;
			ready_hold--;
		end else if (receiver_steady) begin
			m_tready = 1'b1;
		end else begin
			ready_draw = $urandom_range(0, 99);
			if (ready_draw < 70) begin
				m_tready = 1'b1;
			end else begin
				m_tready   = 1'b0;
				ready_hold = (ready_draw < 96) ? $urandom_range(0, 2) : $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("result item arrived with nothing expected");
			end else begin
				oldest_report = expected_reports.pop_front();
				check_field("fired", m_tuser[0], oldest_report.fired);
				check_field("fired_slot", m_tdata[3:0], oldest_report.fired_slot);
				check_field("span", m_tdata[31:4], oldest_report.span);
				check_field("lateness", m_tdata[59:32], oldest_report.lateness);
				check_field("nearest_slot", m_tdata[64:60], oldest_report.nearest_slot);
				check_field("nearest_distance", m_tdata[92:65],
					oldest_report.nearest_distance);
				check_field("last", m_tlast, oldest_report.last);
			end
		end
	end

	initial begin
		model_time    = '0;
		model_soonest = NO_SLOT;
		model_idle    = IDLE_RESET;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			model_deadline[i] = DISARMED;
			model_start[i]    = DISARMED;
		end
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_idle_status();
		test_arm_and_fire();
		test_idle_extremes();
		test_full_table();
		test_random_traffic();
		test_time_wrap();
		wait_for_drain();
		if (mismatch_count == 0) begin
			$display("one_shot_event_scheduler test passed");
		end else begin
			$display("one_shot_event_scheduler test failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("one_shot_event_scheduler test failed");
		$finish;
	end

endmodule
